// ===== design/pphit_pkg.sv =====
// pphit_pkg: shared item codes, status codes and the edge-test result type
// for the polygon point hit test block; no dependencies
package pphit_pkg;

  // width of the point fields on the item ports
  localparam int PT_W = 16;

  typedef enum logic [2:0] {
    K_CLEAR  = 3'd0,
    K_APPEND = 3'd1,
    K_QUERY  = 3'd2,
    K_OFFSET = 3'd3,
    K_MOVE   = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // edge tester back to the sequencer
  typedef struct packed {
    logic vld;   // a tested edge comes out this cycle
    logic hit;   // that edge crosses the ray
    logic pend;  // an edge is still inside the tester
  } edge_res_t;

endpackage

// ===== design/pphit_edge.sv =====
// pphit_edge: two-stage crossing test of one polygon edge against the ray
// running from the query point toward smaller x; uses pphit_pkg
module pphit_edge import pphit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         edge_vld,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [PT_W-1:0]       p_x,
  input  logic signed [PT_W-1:0]       p_y,
  output edge_res_t                    res
);

  localparam int DW = ((COORD_BITS > PT_W) ? COORD_BITS : PT_W) + 1;
  localparam int MW = 2 * DW;

  logic signed [DW-1:0] bx, by, ex, ey, px, py;
  logic signed [DW-1:0] d_ey_by, d_px_bx, d_by_py, d_ex_bx;

  logic                 e1_vld_r;
  logic                 e1_skip_r, e1_num_r;
  logic                 e1_bgt_r, e1_blt_r, e1_elt_r, e1_egt_r, e1_top_r, e1_bot_r;
  logic signed [MW-1:0] e1_p1_r, e1_p2_r;

  logic signed [MW:0]   num;
  logic                 sgn_pos, sgn_neg, hit;
  logic                 res_vld_r, res_hit_r;

  // end with the larger x becomes b
  always_comb begin
    if (a_x < c_x) begin
      bx = DW'(c_x);
      by = DW'(c_y);
      ex = DW'(a_x);
      ey = DW'(a_y);
    end else begin
      bx = DW'(a_x);
      by = DW'(a_y);
      ex = DW'(c_x);
      ey = DW'(c_y);
    end
    px      = DW'(p_x);
    py      = DW'(p_y);
    d_ey_by = ey - by;
    d_px_bx = px - bx;
    d_by_py = by - py;
    d_ex_bx = ex - bx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= edge_vld;
    end
    e1_skip_r <= (ex > px) || (by == ey);
    e1_num_r  <= (bx > px);
    e1_bgt_r  <= (by > py);
    e1_blt_r  <= (by < py);
    e1_elt_r  <= (ey < py);
    e1_egt_r  <= (ey > py);
    e1_top_r  <= (ey == py) && (by > ey);
    e1_bot_r  <= (by == py) && (bx <= px) && (by < ey);
    e1_p1_r   <= MW'(d_ey_by) * MW'(d_px_bx);
    e1_p2_r   <= MW'(d_by_py) * MW'(d_ex_bx);
  end

  // exact slope test: sign of the cross product replaces the float compare
  always_comb begin
    num     = (MW + 1)'(e1_p1_r) + (MW + 1)'(e1_p2_r);
    sgn_pos = e1_num_r ? (num < 0) : e1_bgt_r;
    sgn_neg = e1_num_r ? (num > 0) : e1_blt_r;
    hit     = !e1_skip_r &&
              (e1_top_r || e1_bot_r || (sgn_pos && e1_elt_r) || (sgn_neg && e1_egt_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= e1_vld_r;
    end
    res_hit_r <= hit;
  end

  assign res.vld  = res_vld_r;
  assign res.hit  = res_hit_r;
  assign res.pend = e1_vld_r;

endmodule

// ===== design/polygon_point_hit_test_top.sv =====
// polygon_point_hit_test_top: vertex table in one synchronous memory, box
// registers and the item sequencer; uses pphit_pkg and pphit_edge
//
// usage: an item beat is taken at a rising edge with start high and busy low
// (kind, point_x, point_y). every item gives exactly one result beat: out_valid
// is high for one cycle with inside_res, status and count_now, and the
// receiver must take it then.
// clear, append and a query that misses the box or meets an empty table
// answer in the cycle after the item; busy stays low, so a new item can
// follow at once.
// a query walks the n+1 memory reads of the closed edge list, one a cycle,
// through the two-stage edge tester.
// offset and move read, clamp and write back one vertex a cycle and fix the
// box while the first vertex is read. busy is high meanwhile.
// the read port and the write port meet on one entry only in a cycle with no read issued.
// reset (rst_n low, synchronous) empties the table, zeroes the box and holds
// busy high; vertex memory contents are not cleared and only entries below
// the count are ever used.
module polygon_point_hit_test_top import pphit_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             in_kind,
  input  logic signed [PT_W-1:0]                 in_point_x,
  input  logic signed [PT_W-1:0]                 in_point_y,
  output logic                                   out_valid,
  output logic                                   out_inside_res,
  output logic [1:0]                             out_status,
  output logic [$clog2(MAX_VERTICES + 1)-1:0]    out_count_now
);

  localparam int CW    = COORD_BITS;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = ((CW > PT_W) ? CW : PT_W) + 1;
  localparam int SW    = DW + 1;
  localparam logic [CNT_W-1:0]    MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic signed [SW-1:0] C_HI  = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] C_LO  = ~C_HI;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_QRY   = 5'b00010,
    S_QWAIT = 5'b00100,
    S_SHIFT = 5'b01000,
    S_SWAIT = 5'b10000
  } state_t;

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > C_HI) begin
      r = C_HI[CW-1:0];
    end else if (v < C_LO) begin
      r = C_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic over_c(input logic signed [SW-1:0] v);
    return (v > C_HI) || (v < C_LO);
  endfunction

  // vertex table, {y, x} per entry
  logic [2*CW-1:0] vmem [MAX_VERTICES];
  logic [2*CW-1:0] rd_data_r;
  logic [AW-1:0]   rd_addr, rd_tag_r;
  logic            rd_issue, rd_vld_r, rd_first_r;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [2*CW-1:0] wr_data;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, k_r, k_nxt;
  logic signed [CW-1:0] box_l_r, box_t_r, box_rt_r, box_b_r;
  logic signed [CW-1:0] box_l_nxt, box_t_nxt, box_rt_nxt, box_b_nxt;
  logic signed [PT_W-1:0] px_r, py_r;
  logic signed [DW-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic                 sat_r, sat_nxt, parity_r, parity_nxt;
  logic                 out_valid_r, out_valid_nxt, out_inside_r, out_inside_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  logic                 accept;
  kind_t                kind;
  logic signed [CW-1:0] ax, ay, cur_x, cur_y, prev_x_r, prev_y_r, nx, ny;
  logic signed [SW-1:0] sx, sy;
  logic                 miss, edge_vld;
  edge_res_t            eres;

  assign busy   = (state_r != S_IDLE) || !rst_n;
  assign accept = start && !busy;
  assign kind   = kind_t'(in_kind);

  assign cur_x = rd_data_r[CW-1:0];
  assign cur_y = rd_data_r[2*CW-1:CW];

  assign ax = clamp_c(SW'(in_point_x));
  assign ay = clamp_c(SW'(in_point_y));

  assign sx = SW'(cur_x) + SW'(dx_r);
  assign sy = SW'(cur_y) + SW'(dy_r);
  assign nx = clamp_c(sx);
  assign ny = clamp_c(sy);

  assign miss = (SW'(in_point_x) < SW'(box_l_r)) || (SW'(in_point_y) < SW'(box_t_r)) ||
                (SW'(in_point_x) > SW'(box_rt_r)) || (SW'(in_point_y) > SW'(box_b_r));

  // the read one past the last vertex wraps to entry 0 to close the polygon
  assign rd_addr  = (k_r == cnt_r) ? '0 : k_r[AW-1:0];
  assign rd_issue = (state_r == S_QRY) || ((state_r == S_SHIFT) && (k_r != cnt_r));
  assign edge_vld = rd_vld_r && !rd_first_r && ((state_r == S_QRY) || (state_r == S_QWAIT));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
    rd_data_r <= vmem[rd_addr];
  end

  pphit_edge #(
    .COORD_BITS (CW)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_vld (edge_vld),
    .a_x      (prev_x_r),
    .a_y      (prev_y_r),
    .c_x      (cur_x),
    .c_y      (cur_y),
    .p_x      (px_r),
    .p_y      (py_r),
    .res      (eres)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    box_l_nxt      = box_l_r;
    box_t_nxt      = box_t_r;
    box_rt_nxt     = box_rt_r;
    box_b_nxt      = box_b_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    sat_nxt        = sat_r;
    parity_nxt     = parity_r ^ (eres.vld && eres.hit);
    out_valid_nxt  = 1'b0;
    out_inside_nxt = 1'b0;
    out_status_nxt = ST_OK;
    out_count_nxt  = cnt_r;
    wr_en          = 1'b0;
    wr_addr        = rd_tag_r;
    wr_data        = {ny, nx};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (kind)
            K_CLEAR: begin
              cnt_nxt       = '0;
              box_l_nxt     = '0;
              box_t_nxt     = '0;
              box_rt_nxt    = '0;
              box_b_nxt     = '0;
              out_count_nxt = '0;
            end
            K_APPEND: begin
              if (cnt_r >= MAX_CNT) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = {ay, ax};
                if (cnt_r == '0) begin
                  box_l_nxt  = ax;
                  box_rt_nxt = ax;
                  box_t_nxt  = ay;
                  box_b_nxt  = ay;
                end else begin
                  if (ax < box_l_r)  box_l_nxt  = ax;
                  if (ax > box_rt_r) box_rt_nxt = ax;
                  if (ay < box_t_r)  box_t_nxt  = ay;
                  if (ay > box_b_r)  box_b_nxt  = ay;
                end
                cnt_nxt       = cnt_r + 1'b1;
                out_count_nxt = cnt_r + 1'b1;
              end
            end
            K_QUERY: begin
              if (!miss && (cnt_r != '0)) begin
                out_valid_nxt = 1'b0;
                parity_nxt    = 1'b0;
                k_nxt         = '0;
                state_nxt     = S_QRY;
              end
            end
            K_OFFSET, K_MOVE: begin
              out_valid_nxt = 1'b0;
              if (kind == K_OFFSET) begin
                dx_nxt = DW'(in_point_x);
                dy_nxt = DW'(in_point_y);
              end else begin
                dx_nxt = DW'(in_point_x) - DW'(box_l_r);
                dy_nxt = DW'(in_point_y) - DW'(box_t_r);
              end
              sat_nxt   = 1'b0;
              k_nxt     = '0;
              state_nxt = S_SHIFT;
            end
            default: begin
            end
          endcase
        end
      end
      S_QRY: begin
        k_nxt = k_r + 1'b1;
        if (k_r == cnt_r) begin
          state_nxt = S_QWAIT;
        end
      end
      S_QWAIT: begin
        // last edge has left the tester and its hit is in parity_r
        if (!rd_vld_r && !eres.pend && !eres.vld) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = parity_r;
          state_nxt      = S_IDLE;
        end
      end
      S_SHIFT, S_SWAIT: begin
        if (state_r == S_SHIFT) begin
          if (k_r == '0) begin
            box_l_nxt  = clamp_c(SW'(box_l_r) + SW'(dx_r));
            box_rt_nxt = clamp_c(SW'(box_rt_r) + SW'(dx_r));
            box_t_nxt  = clamp_c(SW'(box_t_r) + SW'(dy_r));
            box_b_nxt  = clamp_c(SW'(box_b_r) + SW'(dy_r));
            if (over_c(SW'(box_l_r) + SW'(dx_r)) || over_c(SW'(box_rt_r) + SW'(dx_r)) ||
                over_c(SW'(box_t_r) + SW'(dy_r)) || over_c(SW'(box_b_r) + SW'(dy_r))) begin
              sat_nxt = 1'b1;
            end
          end
          if (k_r == cnt_r) begin
            state_nxt = S_SWAIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        // write back the vertex read in the previous cycle
        if (rd_vld_r) begin
          wr_en = 1'b1;
          if (over_c(sx) || over_c(sy)) begin
            sat_nxt = 1'b1;
          end
        end
        if ((state_r == S_SWAIT) && !rd_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sat_r ? ST_SAT : ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      box_l_r     <= '0;
      box_t_r     <= '0;
      box_rt_r    <= '0;
      box_b_r     <= '0;
      sat_r       <= 1'b0;
      parity_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      box_l_r     <= box_l_nxt;
      box_t_r     <= box_t_nxt;
      box_rt_r    <= box_rt_nxt;
      box_b_r     <= box_b_nxt;
      sat_r       <= sat_nxt;
      parity_r    <= parity_nxt;
      rd_vld_r    <= rd_issue;
      out_valid_r <= out_valid_nxt;
    end
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    rd_first_r   <= (k_r == '0);
    rd_tag_r     <= rd_addr;
    out_inside_r <= out_inside_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (rd_vld_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_status     = out_status_r;
  assign out_count_now  = out_count_r;

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat while sequencer busy");

  a_accept_ans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || (state_r != S_IDLE)))
    else $error("accepted item neither answered nor in progress");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("vertex count beyond table depth");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == MAX_CNT))
    else $error("table full reported below capacity");

  a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> (out_status_r == ST_OK))
    else $error("inside flag with non-ok status");

endmodule

// ===== test/polygon_point_hit_test_top_tb.sv =====
// polygon_point_hit_test_top_tb: self-checking bench for the polygon point hit test block,
// a directed stimulus table then random polygon sequences, checked by an in-bench predictor
// depends on pphit_pkg and polygon_point_hit_test_top
module polygon_point_hit_test_top_tb import pphit_pkg::*;;

  localparam int MAX_VERT = 64;
  localparam int CNT_W = $clog2(MAX_VERT + 1);
  localparam longint COORD_HI = (longint'(1) <<< (PT_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic [2:0] K_SPARE5 = 3'd5;
  localparam logic [2:0] K_SPARE6 = 3'd6;
  localparam logic [2:0] K_SPARE7 = 3'd7;
  localparam int RAND_ITEMS = 625;
  localparam int SETTLE = MAX_VERT + 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    bit             is_in;
    logic [1:0]     status;
    logic [CNT_W-1:0] held;
  } hit_result_t;

  typedef struct {
    logic [2:0]  kind;
    shortint     x;
    shortint     y;
    bit          pinned;  // expected result typed into the table
    hit_result_t want;
  } hit_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [2:0]            in_kind;
  logic signed [PT_W-1:0] in_point_x;
  logic signed [PT_W-1:0] in_point_y;
  logic                  out_valid;
  logic                  out_inside_res;
  logic [1:0]            out_status;
  logic [CNT_W-1:0]      out_count_now;

  polygon_point_hit_test_top #(
    .MAX_VERTICES(MAX_VERT),
    .COORD_BITS(PT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .out_valid(out_valid),
    .out_inside_res(out_inside_res),
    .out_status(out_status),
    .out_count_now(out_count_now)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // polygon state as the block should hold it
  longint poly_x [MAX_VERT];
  longint poly_y [MAX_VERT];
  int     poly_n;
  longint box_l, box_t, box_r, box_b;
  bit     clamped;

  hit_result_t pending_results[$];
  hit_item_t   directed_rows[$];
  hit_item_t   cur;
  hit_result_t got;
  hit_result_t head;
  bit          holding;
  int          row_idx;
  int          rand_done;
  int          seq_appends, seq_ops, seq_scale;
  int          fault_count = 0;
  int          beat_no = 0;
  int          cycle_count = 0;

  function automatic longint sat_coord(longint v);
    if (v > COORD_HI) begin
      clamped = 1'b1;
      return COORD_HI;
    end
    if (v < COORD_LO) begin
      clamped = 1'b1;
      return COORD_LO;
    end
    return v;
  endfunction

  function automatic bit shift_polygon(longint dx, longint dy);
    int i;
    clamped = 1'b0;
    for (i = 0; i < poly_n; i++) begin
      poly_x[i] = sat_coord(poly_x[i] + dx);
      poly_y[i] = sat_coord(poly_y[i] + dy);
    end
    box_l = sat_coord(box_l + dx);
    box_r = sat_coord(box_r + dx);
    box_t = sat_coord(box_t + dy);
    box_b = sat_coord(box_b + dy);
    return clamped;
  endfunction

  // crossing count of a ray toward smaller x, odd means inside
  function automatic bit ray_parity(longint px, longint py);
    int i, j, sgn;
    int unsigned hits;
    longint bx, by, ex, ey, t, d, num;
    hits = 0;
    if (px < box_l || py < box_t || px > box_r || py > box_b) return 1'b0;
    for (i = 0; i < poly_n; i++) begin
      j = (i + 1 < poly_n) ? i + 1 : 0;
      bx = poly_x[i];
      by = poly_y[i];
      ex = poly_x[j];
      ey = poly_y[j];
      if (bx < ex) begin
        t = bx; bx = ex; ex = t;
        t = by; by = ey; ey = t;
      end
      if (ex > px) continue;
      if (bx > px) begin
        // exact slope test by cross product, d is negative
        d = ex - bx;
        num = (ey - by) * (px - bx) + (by - py) * d;
        sgn = (num < 0) ? 1 : ((num > 0) ? -1 : 0);
      end else begin
        sgn = (by > py) ? 1 : ((by < py) ? -1 : 0);
      end
      if (by == ey) continue;
      if ((ey == py && by > ey) || (by == py && bx <= px && by < ey) ||
          (sgn > 0 && ey < py) || (sgn < 0 && ey > py))
        hits++;
    end
    return hits[0];
  endfunction

  function automatic hit_result_t step_polygon(logic [2:0] kind, longint px, longint py);
    hit_result_t r;
    r.is_in = 1'b0;
    r.status = ST_OK;
    case (kind)
      K_CLEAR: begin
        poly_n = 0;
        box_l = 0;
        box_t = 0;
        box_r = 0;
        box_b = 0;
      end
      K_APPEND: begin
        if (poly_n >= MAX_VERT) begin
          r.status = ST_FULL;
        end else begin
          poly_x[poly_n] = px;
          poly_y[poly_n] = py;
          if (poly_n == 0) begin
            box_l = px;
            box_r = px;
            box_t = py;
            box_b = py;
          end else begin
            if (px < box_l) box_l = px;
            if (px > box_r) box_r = px;
            if (py < box_t) box_t = py;
            if (py > box_b) box_b = py;
          end
          poly_n++;
        end
      end
      K_QUERY: r.is_in = ray_parity(px, py);
      K_OFFSET: if (shift_polygon(px, py)) r.status = ST_SAT;
      K_MOVE: if (shift_polygon(px - box_l, py - box_t)) r.status = ST_SAT;
      default: ;
    endcase
    r.held = poly_n[CNT_W-1:0];
    return r;
  endfunction

  task automatic plan(logic [2:0] kind, int x, int y, bit pinned = 1'b0,
                      bit is_in = 1'b0, logic [1:0] status = ST_OK, int held = 0);
    hit_item_t row;
    row.kind = kind;
    row.x = shortint'(x);
    row.y = shortint'(y);
    row.pinned = pinned;
    row.want.is_in = is_in;
    row.want.status = status;
    row.want.held = held[CNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  function automatic shortint pick_coord(int scale);
    int v;
    case (scale)
      0: v = $urandom_range(0, 24) - 12;
      1: v = $urandom_range(0, 4000) - 2000;
      default: v = $urandom;
    endcase
    return shortint'(v);
  endfunction

  function automatic int idle_pct();
    case ((rand_done / 110) % 3)
      0: return 0;
      1: return 70;
      default: return 6;
    endcase
  endfunction

  // mostly well-formed polygons: clear, a run of vertices, then queries, offsets and moves
  task automatic draw_item(output hit_item_t it);
    int r, v;
    longint qx, qy;
    it.pinned = 1'b0;
    it.want.is_in = 1'b0;
    it.want.status = ST_OK;
    it.want.held = '0;
    if (seq_appends == 0 && seq_ops == 0) begin
      seq_scale = $urandom_range(0, 2);
      seq_appends = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68)
                                                 : $urandom_range(3, 10);
      seq_ops = $urandom_range(6, 16);
      if ($urandom_range(0, 3) != 0) begin
        it.kind = K_CLEAR;
        it.x = pick_coord(2);
        it.y = pick_coord(2);
        return;
      end
    end
    if ($urandom_range(0, 19) == 0) begin
      it.kind = 3'($urandom_range(0, 7));
      it.x = pick_coord(2);
      it.y = pick_coord(2);
      return;
    end
    if (seq_appends > 0) begin
      seq_appends--;
      it.kind = K_APPEND;
      it.x = pick_coord(seq_scale);
      it.y = pick_coord(seq_scale);
      return;
    end
    seq_ops--;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      it.kind = K_OFFSET;
      it.x = pick_coord(($urandom_range(0, 3) == 0) ? 2 : 0);
      it.y = pick_coord(($urandom_range(0, 3) == 0) ? 2 : 0);
      return;
    end
    if (r == 1) begin
      it.kind = K_MOVE;
      if ($urandom_range(0, 1) == 0) begin
        it.x = shortint'(sat_coord(box_l + longint'($urandom_range(0, 40)) - 20));
        it.y = shortint'(sat_coord(box_t + longint'($urandom_range(0, 40)) - 20));
      end else begin
        it.x = pick_coord(2);
        it.y = pick_coord(2);
      end
      return;
    end
    it.kind = K_QUERY;
    r = $urandom_range(0, 9);
    v = (poly_n > 0) ? $urandom_range(0, poly_n - 1) : 0;
    qx = pick_coord(2);
    qy = pick_coord(2);
    if (poly_n > 0 && r < 8) begin
      qx = box_l + longint'($urandom_range(0, 32'(box_r - box_l)));
      qy = box_t + longint'($urandom_range(0, 32'(box_b - box_t)));
      if (r == 4 || r == 5) begin
        qx = poly_x[v];
        qy = poly_y[v];
      end else if (r == 6) begin
        qy = poly_y[v];
      end else if (r == 7) begin
        // just past the left or right side of the box
        qx = sat_coord(($urandom_range(0, 1) == 0) ? box_l - 1 : box_r + 1);
      end
    end
    it.x = shortint'(qx);
    it.y = shortint'(qy);
  endtask

  task automatic note_fault(string msg);
    if (fault_count < 40) $display("mismatch: %s", msg);
    fault_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("result beat %0d with nothing pending", beat_no));
      end else begin
        head = pending_results.pop_front();
        if (out_inside_res !== head.is_in)
          note_fault($sformatf("beat %0d inside_res %b, want %b",
                               beat_no, out_inside_res, head.is_in));
        if (out_status !== head.status)
          note_fault($sformatf("beat %0d status %0d, want %0d",
                               beat_no, out_status, head.status));
        if (out_count_now !== head.held)
          note_fault($sformatf("beat %0d count_now %0d, want %0d",
                               beat_no, out_count_now, head.held));
      end
      beat_no++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("polygon_point_hit_test_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= K_CLEAR;
    in_point_x <= '0;
    in_point_y <= '0;
    poly_n = 0;
    box_l = 0;
    box_t = 0;
    box_r = 0;
    box_b = 0;
    seq_appends = 0;
    seq_ops = 0;
    seq_scale = 0;
    row_idx = 0;
    rand_done = 0;
    holding = 1'b0;
    cur.kind = K_CLEAR;
    cur.x = 0;
    cur.y = 0;
    cur.pinned = 1'b0;

    // empty table, then a full-range square
    plan(K_QUERY, 0, 0, 1'b1, 1'b0, ST_OK, 0);
    plan(K_OFFSET, 5, -3);
    plan(K_MOVE, -7, 9);
    plan(K_CLEAR, 0, 0, 1'b1, 1'b0, ST_OK, 0);
    plan(K_APPEND, -32768, -32768, 1'b1, 1'b0, ST_OK, 1);
    plan(K_APPEND, 32767, -32768, 1'b1, 1'b0, ST_OK, 2);
    plan(K_APPEND, 32767, 32767, 1'b1, 1'b0, ST_OK, 3);
    plan(K_APPEND, -32768, 32767, 1'b1, 1'b0, ST_OK, 4);
    plan(K_QUERY, 0, 0);
    plan(K_QUERY, -32768, -32768);
    plan(K_QUERY, 32767, 0);
    plan(K_OFFSET, 1, 0, 1'b1, 1'b0, ST_SAT, 4);
    plan(K_MOVE, -32768, 32767);
    plan(K_SPARE5, -1, -1, 1'b1, 1'b0, ST_OK, 4);
    plan(K_SPARE6, 0, 0, 1'b1, 1'b0, ST_OK, 4);
    plan(K_SPARE7, 32767, -32768, 1'b1, 1'b0, ST_OK, 4);
    // triangle with a horizontal base, vertex and edge hits
    plan(K_CLEAR, 0, 0, 1'b1, 1'b0, ST_OK, 0);
    plan(K_APPEND, 0, 0, 1'b1, 1'b0, ST_OK, 1);
    plan(K_APPEND, 10, 0, 1'b1, 1'b0, ST_OK, 2);
    plan(K_APPEND, 5, 10, 1'b1, 1'b0, ST_OK, 3);
    plan(K_QUERY, 5, 0);
    plan(K_QUERY, 7, 10);
    plan(K_QUERY, 5, 5);
    plan(K_QUERY, 11, 5, 1'b1, 1'b0, ST_OK, 3);
    plan(K_MOVE, 100, 200);
    plan(K_QUERY, 105, 205);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (holding || row_idx < directed_rows.size() || rand_done < RAND_ITEMS) begin
      @(posedge clk);
      if (start && !busy) begin
        got = step_polygon(cur.kind, cur.x, cur.y);
        pending_results.push_back(cur.pinned ? cur.want : got);
        holding = 1'b0;
      end
      if (!holding) begin
        if (row_idx < directed_rows.size()) begin
          cur = directed_rows[row_idx];
          row_idx++;
          holding = 1'b1;
        end else if (rand_done < RAND_ITEMS && $urandom_range(0, 99) >= idle_pct()) begin
          draw_item(cur);
          if (cur.kind <= K_MOVE) rand_done++;
          holding = 1'b1;
        end
      end
      start <= holding;
      in_kind <= cur.kind;
      in_point_x <= cur.x;
      in_point_y <= cur.y;
    end

    while (pending_results.size() != 0) @(posedge clk);
    // a stray beat after the last one still counts as a fault
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0)
      $display("polygon_point_hit_test_top regression: pass");
    else
      $display("polygon_point_hit_test_top regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pphit_pkg.sv
design/pphit_edge.sv
design/polygon_point_hit_test_top.sv
test/polygon_point_hit_test_top_tb.sv
